[hdl/bcm_pkg.sv]
// battery charge monitor package: widths, conversion constants, codes and
// the structs passed between front end, queue and back end
// no dependencies
package bcm_pkg;

    localparam int ADC_BITS      = 10;
    localparam int VOLT_W        = 13;
    localparam int AMP_W         = 10;
    localparam int CNT_W         = 16;
    localparam int CUR_THR_W     = 10;
    localparam int VTHR_W        = 13;
    localparam int STAT_W        = 2;
    localparam int REQ_W         = 2;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 16;

    // volts = raw * 2560 / 383 in q5.8
    localparam int VOLT_MUL      = 2560;
    localparam int VOLT_DIV      = 383;
    localparam int VOLT_MAX      = 6144;
    localparam int AMP_ZERO      = 510;
    localparam int AMP_MAX       = 512;
    localparam int CHARGE_MARGIN = 120;

    localparam int RECIP_SHIFT   = 20;
    localparam int RECIP_W       = 23;
    localparam longint unsigned RECIP_K =
        (longint'(VOLT_MUL) << RECIP_SHIFT) / VOLT_DIV;
    localparam int PROD_W        = ADC_BITS + RECIP_W;
    localparam int VCALC_W       = ADC_BITS + 12;

    localparam int QUEUE_DEPTH   = 2;
    localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);

    localparam logic [STAT_W-1:0] STAT_CHARGING  = 2'd1;
    localparam logic [STAT_W-1:0] STAT_POWER_ERR = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_CHARGE_THR = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FULL_THR   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LOW_THR    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CRIT_THR   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PERSIST    = 3'd4;

    localparam logic [CUR_THR_W-1:0] RST_CHARGE_THR = 10'd4;
    localparam logic [VTHR_W-1:0]    RST_FULL_THR   = 13'd3226;
    localparam logic [VTHR_W-1:0]    RST_LOW_THR    = 13'd2816;
    localparam logic [VTHR_W-1:0]    RST_CRIT_THR   = 13'd2688;
    localparam logic [CNT_W-1:0]     RST_PERSIST    = 16'd600;

    typedef enum logic [REQ_W-1:0] {
        REQ_NONE      = 2'd0,
        REQ_CHARGING  = 2'd1,
        REQ_READY     = 2'd2,
        REQ_POWER_ERR = 2'd3
    } req_t;

    typedef struct packed {
        logic [CUR_THR_W-1:0] charge_thr;
        logic [VTHR_W-1:0]    full_thr;
        logic [VTHR_W-1:0]    low_thr;
        logic [VTHR_W-1:0]    crit_thr;
        logic [CNT_W-1:0]     persist;
    } cfg_t;

    typedef struct packed {
        logic high_amp;
        logic at_full;
        logic below_low;
        logic critical;
    } cls_t;

    typedef struct packed {
        logic [VOLT_W-1:0] volt;
        logic [AMP_W-1:0]  amp;
        logic [STAT_W-1:0] status;
        cls_t              cls;
    } item_t;

    typedef struct packed {
        logic [VOLT_W-1:0] volt;
        logic [AMP_W-1:0]  amp;
        logic              charging;
        logic              charged;
        logic              battery_low;
        logic              critical;
        req_t              req;
    } result_t;

endpackage

[hdl/bcm_front.sv]
// front end: takes samples, converts voltage and current, classifies
// against the thresholds and hands items to the queue; uses bcm_pkg
module bcm_front (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         push,
    output logic                         full,
    input  logic [bcm_pkg::ADC_BITS-1:0] volt_sample,
    input  logic [bcm_pkg::ADC_BITS-1:0] amp_sample,
    input  logic [bcm_pkg::STAT_W-1:0]   machine_status,
    input  bcm_pkg::cfg_t                cfg,
    output logic                         item_push,
    input  logic                         item_full,
    output bcm_pkg::item_t               item
);
    import bcm_pkg::*;

    logic                  s1_valid_reg;
    logic                  s1_valid_next;
    logic [ADC_BITS-1:0]   s1_vraw_reg;
    logic [VCALC_W-1:0]    s1_qest_reg;
    logic [AMP_W-1:0]      s1_amp_reg;
    logic [STAT_W-1:0]     s1_status_reg;

    logic                  accept;
    logic [PROD_W-1:0]     prod;
    logic [VCALC_W-1:0]    qest;
    logic [ADC_BITS:0]     araw;
    logic [ADC_BITS:0]     adiff;
    logic [AMP_W-1:0]      amp;

    logic [VCALC_W-1:0]    scaled;
    logic [VCALC_W-1:0]    qmul;
    logic [VCALC_W-1:0]    rem;
    logic [VCALC_W-1:0]    qfix;
    logic [VCALC_W-1:0]    qsat;
    logic [VOLT_W-1:0]     volt;

    assign full      = s1_valid_reg && item_full;
    assign accept    = push && !full;
    assign item_push = s1_valid_reg && !item_full;

    // reciprocal estimate, one low at most
    assign prod = PROD_W'(volt_sample) * PROD_W'(RECIP_K);
    assign qest = VCALC_W'(prod >> RECIP_SHIFT);

    always_comb
    begin
        araw  = {1'b0, amp_sample};
        adiff = '0;
        if (araw > (ADC_BITS+1)'(AMP_ZERO))
        begin
            adiff = araw - (ADC_BITS+1)'(AMP_ZERO);
        end
        if (adiff > (ADC_BITS+1)'(AMP_MAX))
        begin
            amp = AMP_W'(AMP_MAX);
        end
        else
        begin
            amp = AMP_W'(adiff);
        end
    end

    assign s1_valid_next = accept ? 1'b1 : (item_push ? 1'b0 : s1_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_vraw_reg   <= volt_sample;
            s1_qest_reg   <= qest;
            s1_amp_reg    <= amp;
            s1_status_reg <= machine_status;
        end
    end

    // exact floor by remainder check, then saturate at 24 V
    always_comb
    begin
        scaled = (VCALC_W'(s1_vraw_reg) << 11) + (VCALC_W'(s1_vraw_reg) << 9);
        qmul   = (s1_qest_reg << 9) - (s1_qest_reg << 7) - s1_qest_reg;
        rem    = scaled - qmul;
        qfix   = (rem >= VCALC_W'(VOLT_DIV)) ? s1_qest_reg + 1'b1 : s1_qest_reg;
        qsat   = (qfix > VCALC_W'(VOLT_MAX)) ? VCALC_W'(VOLT_MAX) : qfix;
        volt   = VOLT_W'(qsat);
    end

    always_comb
    begin
        item.volt          = volt;
        item.amp           = s1_amp_reg;
        item.status        = s1_status_reg;
        item.cls.high_amp  = s1_amp_reg > cfg.charge_thr;
        item.cls.at_full   = volt >= cfg.full_thr;
        item.cls.below_low = volt < cfg.low_thr;
        item.cls.critical  = volt <= cfg.crit_thr;
    end

endmodule

[hdl/bcm_queue.sv]
// short queue of classified items between front end and back end
// uses bcm_pkg
module bcm_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    output logic           full,
    input  bcm_pkg::item_t din,
    input  logic           pop,
    output logic           empty,
    output bcm_pkg::item_t dout
);
    import bcm_pkg::*;

    item_t              mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg;
    logic [QPTR_W-1:0]  rd_ptr_reg;
    logic [QCNT_W-1:0]  count_reg;
    logic [QCNT_W-1:0]  count_next;
    logic               do_push;
    logic               do_pop;

    assign full    = count_reg == QCNT_W'(QUEUE_DEPTH);
    assign empty   = count_reg == '0;
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign dout    = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= din;
        end
    end

endmodule

[hdl/bcm_back.sv]
// back end: persistence counters, flags and status request, with a
// two-entry result buffer on the output side; uses bcm_pkg
module bcm_back (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic [bcm_pkg::CNT_W-1:0] persist,
    input  logic                      item_empty,
    output logic                      item_pop,
    input  bcm_pkg::item_t            item,
    input  logic                      pop,
    output logic                      empty,
    output bcm_pkg::result_t          result
);
    import bcm_pkg::*;

    logic [CNT_W-1:0]   hold_count_reg;
    logic [CNT_W-1:0]   hold_count_next;
    logic [CNT_W-1:0]   full_count_reg;
    logic [CNT_W-1:0]   full_count_next;
    logic [CNT_W-1:0]   low_count_reg;
    logic [CNT_W-1:0]   low_count_next;

    logic [CNT_W-1:0]   full_cap;
    logic [CNT_W-1:0]   charge_bound;
    result_t            res;

    result_t            res_mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  res_wr_reg;
    logic [QPTR_W-1:0]  res_rd_reg;
    logic [QCNT_W-1:0]  res_count_reg;
    logic [QCNT_W-1:0]  res_count_next;
    logic               res_pop;

    assign item_pop = !item_empty && (res_count_reg != QCNT_W'(QUEUE_DEPTH));
    assign empty    = res_count_reg == '0;
    assign res_pop  = pop && !empty;
    assign result   = res_mem_reg[res_rd_reg];

    assign full_cap     = (persist == '1) ? persist : persist + 1'b1;
    assign charge_bound = (persist >= CNT_W'(CHARGE_MARGIN)) ?
                          persist - CNT_W'(CHARGE_MARGIN) : '0;

    always_comb
    begin
        if (item.cls.high_amp)
        begin
            hold_count_next = persist;
        end
        else if (hold_count_reg != '0)
        begin
            hold_count_next = hold_count_reg - 1'b1;
        end
        else
        begin
            hold_count_next = hold_count_reg;
        end

        if (!item.cls.at_full)
        begin
            full_count_next = '0;
        end
        else if (full_count_reg < full_cap)
        begin
            full_count_next = full_count_reg + 1'b1;
        end
        else
        begin
            full_count_next = full_count_reg;
        end

        if (!item.cls.below_low)
        begin
            low_count_next = '0;
        end
        else if (low_count_reg < persist)
        begin
            low_count_next = low_count_reg + 1'b1;
        end
        else
        begin
            low_count_next = low_count_reg;
        end
    end

    always_comb
    begin
        res.volt        = item.volt;
        res.amp         = item.amp;
        res.charging    = hold_count_next >= charge_bound;
        res.charged     = full_count_next >= persist;
        res.battery_low = low_count_next >= persist;
        res.critical    = item.cls.critical;
        if (res.charging && item.status != STAT_CHARGING)
        begin
            res.req = REQ_CHARGING;
        end
        else if (!res.charging && item.status == STAT_CHARGING)
        begin
            res.req = REQ_READY;
        end
        else if (res.critical && item.status != STAT_POWER_ERR)
        begin
            res.req = REQ_POWER_ERR;
        end
        else if (!res.critical && item.status == STAT_POWER_ERR)
        begin
            res.req = REQ_READY;
        end
        else
        begin
            res.req = REQ_NONE;
        end
    end

    always_comb
    begin
        res_count_next = res_count_reg;
        if (item_pop && !res_pop)
        begin
            res_count_next = res_count_reg + 1'b1;
        end
        else if (res_pop && !item_pop)
        begin
            res_count_next = res_count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_count_reg <= '0;
            full_count_reg <= '0;
            low_count_reg  <= '0;
            res_wr_reg     <= '0;
            res_rd_reg     <= '0;
            res_count_reg  <= '0;
        end
        else
        begin
            if (item_pop)
            begin
                hold_count_reg <= hold_count_next;
                full_count_reg <= full_count_next;
                low_count_reg  <= low_count_next;
                res_wr_reg     <= (res_wr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : res_wr_reg + 1'b1;
            end
            if (res_pop)
            begin
                res_rd_reg <= (res_rd_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : res_rd_reg + 1'b1;
            end
            res_count_reg <= res_count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_pop)
        begin
            res_mem_reg[res_wr_reg] <= res;
        end
    end

    a_hold_reload: assert property (@(posedge clk) disable iff (!rst_n)
        item_pop && item.cls.high_amp |=> hold_count_reg == $past(persist))
        else $error("charge hold counter did not reload");

    a_full_clear: assert property (@(posedge clk) disable iff (!rst_n)
        item_pop && !item.cls.at_full |=> full_count_reg == '0)
        else $error("full counter did not clear");

    a_res_drain: assert property (@(posedge clk) disable iff (!rst_n)
        res_pop && !item_pop |=> res_count_reg == $past(res_count_reg) - 1'b1)
        else $error("result buffer count wrong after transfer out");

endmodule

[hdl/battery_charge_monitor_top.sv]
// battery charge monitor top level: configuration registers and the
// front end, item queue and back end; uses bcm_pkg, bcm_front, bcm_queue, bcm_back
//
// One result per accepted sample set, one set per clock sustained while
// results are popped and no buffer is full. A set is converted in the front
// end over two stages (reciprocal multiply, then a remainder correction and
// threshold compares), waits in a two-entry queue, and the back end updates
// the persistence counters and forms the flags and status request as it
// takes each item, so its counter update sets the rate of one item per
// clock. A set passes the front-end register, the queue and the result
// buffer on its way out; that two-entry buffer lets input keep flowing
// while results wait. Configuration writes are always ready and take effect
// at once; write them only while the block is idle. No clearing pass after reset.
module battery_charge_monitor_top (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic [bcm_pkg::ADC_BITS-1:0]  volt_sample,
    input  logic [bcm_pkg::ADC_BITS-1:0]  amp_sample,
    input  logic [bcm_pkg::STAT_W-1:0]    machine_status,
    input  logic                          pop,
    output logic                          empty,
    output logic [bcm_pkg::VOLT_W-1:0]    volt_q8,
    output logic [bcm_pkg::AMP_W-1:0]     amp_units,
    output logic                          charging,
    output logic                          charged,
    output logic                          battery_low,
    output logic                          critical,
    output logic [bcm_pkg::REQ_W-1:0]     status_request,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [bcm_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [bcm_pkg::CFG_DATA_W-1:0] cfg_data
);
    import bcm_pkg::*;

    cfg_t    cfg_reg;
    logic    item_push;
    logic    item_full;
    item_t   front_item;
    logic    item_pop;
    logic    item_empty;
    item_t   back_item;
    result_t result;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.charge_thr <= RST_CHARGE_THR;
            cfg_reg.full_thr   <= RST_FULL_THR;
            cfg_reg.low_thr    <= RST_LOW_THR;
            cfg_reg.crit_thr   <= RST_CRIT_THR;
            cfg_reg.persist    <= RST_PERSIST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_CHARGE_THR: cfg_reg.charge_thr <= cfg_data[CUR_THR_W-1:0];
                REG_FULL_THR:   cfg_reg.full_thr   <= cfg_data[VTHR_W-1:0];
                REG_LOW_THR:    cfg_reg.low_thr    <= cfg_data[VTHR_W-1:0];
                REG_CRIT_THR:   cfg_reg.crit_thr   <= cfg_data[VTHR_W-1:0];
                REG_PERSIST:    cfg_reg.persist    <= cfg_data[CNT_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    bcm_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .full           (full),
        .volt_sample    (volt_sample),
        .amp_sample     (amp_sample),
        .machine_status (machine_status),
        .cfg            (cfg_reg),
        .item_push      (item_push),
        .item_full      (item_full),
        .item           (front_item)
    );

    bcm_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (item_push),
        .full  (item_full),
        .din   (front_item),
        .pop   (item_pop),
        .empty (item_empty),
        .dout  (back_item)
    );

    bcm_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .persist    (cfg_reg.persist),
        .item_empty (item_empty),
        .item_pop   (item_pop),
        .item       (back_item),
        .pop        (pop),
        .empty      (empty),
        .result     (result)
    );

    assign volt_q8        = result.volt;
    assign amp_units      = result.amp;
    assign charging       = result.charging;
    assign charged        = result.charged;
    assign battery_low    = result.battery_low;
    assign critical       = result.critical;
    assign status_request = result.req;

endmodule

[test/tb_battery_charge_monitor_top.sv]
// testbench for battery_charge_monitor_top: directed and random sensor ticks,
// each result checked against an in-bench model of the monitor
// depends on bcm_pkg and battery_charge_monitor_top
module tb_battery_charge_monitor_top;
    timeunit 1ns;
    timeprecision 1ps;

    import bcm_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int IDLE_PCT    = 17;
    localparam int PHASE_TICKS = 160;

    localparam logic [STAT_W-1:0]    STAT_OTHER   = 2'd0;
    localparam logic [STAT_W-1:0]    STAT_UNUSED  = 2'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

    logic                  clk            = 1'b0;
    logic                  rst_n          = 1'b0;
    logic                  push           = 1'b0;
    logic                  full;
    logic [ADC_BITS-1:0]   volt_sample    = '0;
    logic [ADC_BITS-1:0]   amp_sample     = '0;
    logic [STAT_W-1:0]     machine_status = '0;
    logic                  pop            = 1'b0;
    logic                  empty;
    logic [VOLT_W-1:0]     volt_q8;
    logic [AMP_W-1:0]      amp_units;
    logic                  charging;
    logic                  charged;
    logic                  battery_low;
    logic                  critical;
    logic [REQ_W-1:0]      status_request;
    logic                  cfg_valid      = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index      = '0;
    logic [CFG_DATA_W-1:0] cfg_data       = '0;

    cfg_t             model_cfg;
    logic [CNT_W-1:0] hold_count;
    logic [CNT_W-1:0] full_run;
    logic [CNT_W-1:0] low_run;
    result_t          pending_readings[$];

    int cycle_count    = 0;
    int mismatch_count = 0;
    bit no_idle        = 1'b0;
    int hold_seq       = 0;
    int hold_len       = 0;

    battery_charge_monitor_top i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .full           (full),
        .volt_sample    (volt_sample),
        .amp_sample     (amp_sample),
        .machine_status (machine_status),
        .pop            (pop),
        .empty          (empty),
        .volt_q8        (volt_q8),
        .amp_units      (amp_units),
        .charging       (charging),
        .charged        (charged),
        .battery_low    (battery_low),
        .critical       (critical),
        .status_request (status_request),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("CHECK FAILED");
        $finish;
    end

    function automatic result_t predict_reading(logic [ADC_BITS-1:0] vraw,
                                                logic [ADC_BITS-1:0] araw,
                                                logic [STAT_W-1:0] stat);
        int unsigned volt;
        int unsigned amp;
        int unsigned span;
        int unsigned full_cap;
        int unsigned bound;
        result_t     r;
        span = 32'(model_cfg.persist);
        volt = vraw * VOLT_MUL / VOLT_DIV;
        if (volt > VOLT_MAX)
            volt = VOLT_MAX;
        amp = (araw > AMP_ZERO) ? araw - AMP_ZERO : 0;
        if (amp > AMP_MAX)
            amp = AMP_MAX;

        if (amp > model_cfg.charge_thr)
            hold_count = model_cfg.persist;
        else if (hold_count != 0)
            hold_count = hold_count - 1'b1;

        full_cap = (span + 1 > 16'hFFFF) ? 16'hFFFF : span + 1;
        if (volt >= model_cfg.full_thr)
        begin
            if (full_run < full_cap)
                full_run = full_run + 1'b1;
        end
        else
            full_run = '0;

        if (volt < model_cfg.low_thr)
        begin
            if (low_run < span)
                low_run = low_run + 1'b1;
        end
        else
            low_run = '0;

        bound = (span >= CHARGE_MARGIN) ? span - CHARGE_MARGIN : 0;
        r.volt        = volt[VOLT_W-1:0];
        r.amp         = amp[AMP_W-1:0];
        r.charging    = hold_count >= bound;
        r.charged     = full_run >= span;
        r.battery_low = low_run >= span;
        r.critical    = volt <= model_cfg.crit_thr;

        if (r.charging && stat != STAT_CHARGING)
            r.req = REQ_CHARGING;
        else if (!r.charging && stat == STAT_CHARGING)
            r.req = REQ_READY;
        else if (r.critical && stat != STAT_POWER_ERR)
            r.req = REQ_POWER_ERR;
        else if (!r.critical && stat == STAT_POWER_ERR)
            r.req = REQ_READY;
        else
            r.req = REQ_NONE;
        return r;
    endfunction

    function automatic void apply_register(logic [CFG_IDX_W-1:0] idx,
                                           logic [CFG_DATA_W-1:0] data);
        case (idx)
            REG_CHARGE_THR: model_cfg.charge_thr = data[CUR_THR_W-1:0];
            REG_FULL_THR:   model_cfg.full_thr   = data[VTHR_W-1:0];
            REG_LOW_THR:    model_cfg.low_thr    = data[VTHR_W-1:0];
            REG_CRIT_THR:   model_cfg.crit_thr   = data[VTHR_W-1:0];
            REG_PERSIST:    model_cfg.persist    = data[CNT_W-1:0];
            default: ;
        endcase
    endfunction

    task automatic check_reading();
        result_t seen;
        result_t want;
        seen = '{volt_q8, amp_units, charging, charged, battery_low, critical,
                 req_t'(status_request)};
        if (pending_readings.size() == 0)
        begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("cycle %0d: result with nothing expected", cycle_count);
        end
        else
        begin
            want = pending_readings.pop_front();
            if (seen.volt !== want.volt || seen.amp !== want.amp ||
                seen.charging !== want.charging || seen.charged !== want.charged ||
                seen.battery_low !== want.battery_low ||
                seen.critical !== want.critical || seen.req !== want.req)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("cycle %0d: expected v=%0d a=%0d c=%b f=%b l=%b k=%b r=%0d %s",
                             cycle_count, want.volt, want.amp, want.charging,
                             want.charged, want.battery_low, want.critical, want.req,
                             $sformatf("got v=%0d a=%0d c=%b f=%b l=%b k=%b r=%0d",
                                       seen.volt, seen.amp, seen.charging, seen.charged,
                                       seen.battery_low, seen.critical, seen.req));
            end
        end
    endtask

    // result side: transfer decided mid-cycle, taken at the next rising edge
    always @(negedge clk)
    begin
        if (rst_n && pop && !empty)
            check_reading();
    end

    // result side: random pop, plus hold-off stretches requested by the tests
    int hold_seen = 0;
    int hold_left = 0;
    always @(posedge clk)
    begin
        if (hold_seq != hold_seen)
        begin
            hold_seen = hold_seq;
            hold_left = hold_len;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            pop <= 1'b0;
        end
        else
            pop <= no_idle || ($urandom_range(99) >= IDLE_PCT);
    end

    task automatic send_sample(logic [ADC_BITS-1:0] v, logic [ADC_BITS-1:0] a,
                               logic [STAT_W-1:0] stat);
        while (!no_idle && $urandom_range(99) < IDLE_PCT)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push           <= 1'b1;
        volt_sample    <= v;
        amp_sample     <= a;
        machine_status <= stat;
        @(negedge clk);
        while (full)
            @(negedge clk);
        @(posedge clk);
        pending_readings.push_back(predict_reading(v, a, stat));
    endtask

    task automatic drain_readings();
        push <= 1'b0;
        while (pending_readings.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // leaves cfg_valid high so back-to-back writes need no gap
    task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        apply_register(idx, data);
    endtask

    task automatic configure(logic [CFG_DATA_W-1:0] charge_thr, logic [CFG_DATA_W-1:0] full_thr,
                             logic [CFG_DATA_W-1:0] low_thr, logic [CFG_DATA_W-1:0] crit_thr,
                             logic [CFG_DATA_W-1:0] persist);
        drain_readings();
        write_register(REG_CHARGE_THR, charge_thr);
        write_register(REG_FULL_THR, full_thr);
        write_register(REG_LOW_THR, low_thr);
        write_register(REG_CRIT_THR, crit_thr);
        write_register(REG_PERSIST, persist);
        cfg_valid <= 1'b0;
    endtask

    task automatic test_reset_values();
        send_sample(10'd0, 10'd510, STAT_OTHER);
        send_sample(10'd1023, 10'd1023, STAT_CHARGING);
        send_sample(10'd1023, 10'd0, STAT_POWER_ERR);
        send_sample(10'd0, 10'd1023, STAT_UNUSED);
        send_sample(10'd383, 10'd511, STAT_OTHER);
        send_sample(10'd402, 10'd514, STAT_POWER_ERR);
        send_sample(10'd403, 10'd515, STAT_UNUSED);
        send_sample(10'd482, 10'd1022, STAT_CHARGING);
        send_sample(10'd483, 10'd509, STAT_OTHER);
        send_sample(10'd421, 10'd2, STAT_POWER_ERR);
        send_sample(10'd422, 10'd600, STAT_CHARGING);
        send_sample(10'd919, 10'h155, STAT_OTHER);
        send_sample(10'd920, 10'h2AA, STAT_POWER_ERR);
        send_sample(10'h2AA, 10'h155, STAT_UNUSED);
        send_sample(10'h155, 10'h2AA, STAT_CHARGING);
        send_sample(10'd1, 10'd512, STAT_OTHER);
    endtask

    // short persistence, masked wide values, writes past the last register
    task automatic test_short_persistence();
        drain_readings();
        write_register(REG_SPARE_LO, 16'hFFFF);
        write_register(REG_SPARE_HI, 16'hAAAA);
        write_register(REG_CHARGE_THR, 16'hFFFF);
        write_register(REG_FULL_THR, 16'hE000);
        write_register(REG_LOW_THR, 16'hFFFF);
        write_register(REG_CRIT_THR, 16'h2000);
        write_register(REG_PERSIST, 16'd3);
        cfg_valid <= 1'b0;
        send_sample(10'd700, 10'd1023, STAT_OTHER);
        send_sample(10'd700, 10'd800, STAT_CHARGING);
        send_sample(10'd0, 10'd510, STAT_POWER_ERR);
        send_sample(10'd1023, 10'd0, STAT_UNUSED);
        send_sample(10'd500, 10'd1023, STAT_CHARGING);
        send_sample(10'd500, 10'd511, STAT_OTHER);
        send_sample(10'd0, 10'd0, STAT_POWER_ERR);
        send_sample(10'd1023, 10'd1023, STAT_OTHER);
    endtask

    task automatic test_back_pressure();
        int i;
        configure(CFG_DATA_W'(RST_CHARGE_THR), CFG_DATA_W'(RST_FULL_THR),
                  CFG_DATA_W'(RST_LOW_THR), CFG_DATA_W'(RST_CRIT_THR),
                  CFG_DATA_W'(RST_PERSIST));
        hold_len = 300;
        hold_seq++;
        no_idle  = 1'b1;
        for (i = 0; i < 40; i++)
            send_sample(ADC_BITS'($urandom_range(1023)), ADC_BITS'($urandom_range(1023)),
                        STAT_W'($urandom_range(3)));
        no_idle  = 1'b0;
    endtask

    task automatic test_random_phases();
        int               phase;
        int               sent;
        int               run_len;
        int               base_v;
        int               v;
        int               a;
        int               i;
        bit               high_amp;
        logic [STAT_W-1:0] stat;
        for (phase = 0; phase < 8; phase++)
        begin
            case (phase)
                0: configure(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
                1: configure(16'h03FF, 16'h1FFF, 16'h1FFF, 16'h1FFF, 16'hFFFF);
                2: configure(16'd512, 16'd6144, 16'd6144, 16'd6144, 16'd121);
                3: configure(CFG_DATA_W'(RST_CHARGE_THR), CFG_DATA_W'(RST_FULL_THR),
                             CFG_DATA_W'(RST_LOW_THR), CFG_DATA_W'(RST_CRIT_THR),
                             16'd65534);
                default: configure(CFG_DATA_W'($urandom_range(40)),
                                   CFG_DATA_W'($urandom_range(6144)),
                                   CFG_DATA_W'($urandom_range(6144)),
                                   CFG_DATA_W'($urandom_range(6144)),
                                   CFG_DATA_W'($urandom_range(150)));
            endcase
            no_idle = (phase == 5);
            sent = 0;
            while (sent < PHASE_TICKS)
            begin
                if ($urandom_range(99) < 15)
                begin
                    send_sample(ADC_BITS'($urandom_range(1023)),
                                ADC_BITS'($urandom_range(1023)),
                                STAT_W'($urandom_range(3)));
                    sent++;
                end
                else
                begin
                    run_len  = int'($urandom_range(8, 120));
                    base_v   = int'($urandom_range(1023));
                    high_amp = 1'($urandom_range(1));
                    stat     = STAT_W'($urandom_range(3));
                    for (i = 0; i < run_len && sent < PHASE_TICKS; i++)
                    begin
                        v = base_v + int'($urandom_range(4)) - 2;
                        if (v < 0)
                            v = 0;
                        if (v > 1023)
                            v = 1023;
                        if (high_amp && $urandom_range(9) != 0)
                            a = AMP_ZERO + model_cfg.charge_thr + 1 + int'($urandom_range(15));
                        else
                            a = int'($urandom_range(AMP_ZERO + model_cfg.charge_thr));
                        if (a > 1023)
                            a = 1023;
                        if ($urandom_range(19) == 0)
                            stat = STAT_W'($urandom_range(3));
                        send_sample(ADC_BITS'(v), ADC_BITS'(a), stat);
                        sent++;
                    end
                end
            end
        end
        no_idle = 1'b0;
    endtask

    initial
    begin
        model_cfg  = '{RST_CHARGE_THR, RST_FULL_THR, RST_LOW_THR, RST_CRIT_THR, RST_PERSIST};
        hold_count = '0;
        full_run   = '0;
        low_run    = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_values();
        test_short_persistence();
        test_back_pressure();
        test_random_phases();
        drain_readings();
        if (mismatch_count == 0 && pending_readings.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

[sim.f]
hdl/bcm_pkg.sv
hdl/bcm_front.sv
hdl/bcm_queue.sv
hdl/bcm_back.sv
hdl/battery_charge_monitor_top.sv
test/tb_battery_charge_monitor_top.sv
